>>> hw/rtl/anl_pkg.sv
// Package for the ASCII number to limbs converter.
// Item payload types, status codes and character constants; no dependencies.

package anl_pkg;

   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;
   localparam logic [7:0] CH_LO_A  = 8'h61;
   localparam logic [7:0] CH_LO_F  = 8'h66;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_F  = 8'h46;
   localparam logic [7:0] CH_LO_X  = 8'h78;
   localparam logic [7:0] CH_UP_X  = 8'h58;

   localparam logic [1:0] STATUS_OK       = 2'd0;
   localparam logic [1:0] STATUS_INVALID  = 2'd1;
   localparam logic [1:0] STATUS_OVERFLOW = 2'd2;

   typedef struct packed {
      logic       start_new;
      logic [7:0] char_code;
      logic       final_char;
   } anl_req_type;

   typedef struct packed {
      logic [63:0] limb_value;
      logic [3:0]  limb_index;
      logic [1:0]  status;
      logic        last_limb;
   } anl_rsp_type;

endpackage

>>> hw/rtl/ascii_number_to_limbs_core.sv
// ASCII number to multi-limb binary converter, top level.
// Uses anl_pkg for payload types, status codes and character constants.
//
//  channel   dir   handshake              payload
//  req       in    req_valid / req_stall  anl_req_type, one character per item
//  rsp       out   rsp_valid / rsp_stall  anl_rsp_type, LIMBS items per final char
//  csr       in    csr_wr_en              csr_wr_data = base_mode
//
// A digit is accepted in the idle state, then runs through the shared 64-bit
// multiply-add (x10 or x16 plus carry), one limb per cycle; skipped or invalid
// characters skip the multiply-add. A final character then emits the LIMBS
// limbs, which rsp_stall can hold. req_stall is high except in the idle state.
// Reset clears the accumulator, status and base_mode.

module ascii_number_to_limbs_core
   import anl_pkg::*;
#(
   parameter int LIMBS = 4
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  anl_req_type req_payload,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output anl_rsp_type rsp_payload,
   input  logic        csr_wr_en,
   input  logic        csr_wr_data
);

   localparam int CNT_W = (LIMBS > 1) ? $clog2(LIMBS) : 1;
   localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(LIMBS - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MAC  = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;

   logic [1:0]       state_ff, state_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [63:0]      acc_ff [LIMBS];
   logic [63:0]      acc_in [LIMBS];
   logic [3:0]       carry_ff, carry_in;
   logic [1:0]       status_ff, status_in;
   logic [1:0]       pos_ff, pos_in;
   logic             fwz_ff, fwz_in;
   logic             mode_ff, mode_in;
   logic             hex_ff, hex_in;
   logic             final_ff, final_in;
   logic             rsp_valid_ff, rsp_valid_in;
   anl_rsp_type      rsp_ff, rsp_in;

   logic [67:0]      mac_sum;
   logic             accept;
   logic             digit_ok;
   logic [3:0]       digit;
   logic             skip;
   logic [1:0]       eff_status;
   logic [1:0]       eff_pos;
   logic             eff_fwz;
   logic             load_rsp;

   always_comb begin
      digit_ok = 1'b1;
      digit    = req_payload.char_code[3:0];
      if (req_payload.char_code inside {[CH_0:CH_9]}) begin
         digit = 4'(req_payload.char_code - CH_0);
      end else if (mode_ff && (req_payload.char_code inside {[CH_LO_A:CH_LO_F]})) begin
         digit = 4'(req_payload.char_code - CH_LO_A + 8'd10);
      end else if (mode_ff && (req_payload.char_code inside {[CH_UP_A:CH_UP_F]})) begin
         digit = 4'(req_payload.char_code - CH_UP_A + 8'd10);
      end else begin
         digit_ok = 1'b0;
      end
   end

   assign accept     = req_valid && !req_stall;
   assign eff_status = req_payload.start_new ? STATUS_OK : status_ff;
   assign eff_pos    = req_payload.start_new ? 2'd0 : pos_ff;
   assign eff_fwz    = req_payload.start_new ? 1'b0 : fwz_ff;
   assign skip       = mode_ff && (eff_pos == 2'd1) && eff_fwz
                       && ((req_payload.char_code == CH_LO_X)
                           || (req_payload.char_code == CH_UP_X));

   // shared unit: limb * base + carry, limb 0 of the rotating accumulator
   assign mac_sum = (hex_ff ? {acc_ff[0], 4'b0000}
                            : ({1'b0, acc_ff[0], 3'b000} + {3'b000, acc_ff[0], 1'b0}))
                    + {64'd0, carry_ff};

   assign load_rsp = (state_ff == ST_EMIT) && (!rsp_valid_ff || !rsp_stall);

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      acc_in       = acc_ff;
      carry_in     = carry_ff;
      status_in    = status_ff;
      pos_in       = pos_ff;
      fwz_in       = fwz_ff;
      mode_in      = csr_wr_en ? csr_wr_data : mode_ff;
      hex_in       = hex_ff;
      final_in     = final_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_in       = rsp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               final_in = req_payload.final_char;
               hex_in   = mode_ff;
               cnt_in   = '0;
               if (req_payload.start_new) begin
                  for (int i = 0; i < LIMBS; i++) begin
                     acc_in[i] = '0;
                  end
               end
               status_in = eff_status;
               pos_in    = eff_pos;
               fwz_in    = eff_fwz;
               state_in  = req_payload.final_char ? ST_EMIT : ST_IDLE;
               if (eff_status == STATUS_OK) begin
                  if (!skip) begin
                     if (!digit_ok) begin
                        status_in = STATUS_INVALID;
                     end else begin
                        carry_in = digit;
                        state_in = ST_MAC;
                     end
                  end
                  if (eff_pos == 2'd0) begin
                     fwz_in = (req_payload.char_code == CH_0);
                  end
                  if (eff_pos != 2'd2) begin
                     pos_in = eff_pos + 2'd1;
                  end
               end
            end
         end
         ST_MAC: begin
            // rotate: processed limb goes to the top, next limb comes to slot 0
            for (int i = 0; i < LIMBS - 1; i++) begin
               acc_in[i] = acc_ff[i+1];
            end
            acc_in[LIMBS-1] = mac_sum[63:0];
            carry_in        = mac_sum[67:64];
            cnt_in          = cnt_ff + 1'b1;
            if (cnt_ff == CNT_LAST) begin
               cnt_in = '0;
               if (mac_sum[67:64] != 4'd0) begin
                  status_in = STATUS_OVERFLOW;
               end
               state_in = final_ff ? ST_EMIT : ST_IDLE;
            end
         end
         ST_EMIT: begin
            if (load_rsp) begin
               rsp_valid_in          = 1'b1;
               rsp_in.limb_value     = acc_ff[0];
               rsp_in.limb_index     = 4'(cnt_ff);
               rsp_in.status         = status_ff;
               rsp_in.last_limb      = (cnt_ff == CNT_LAST);
               for (int i = 0; i < LIMBS - 1; i++) begin
                  acc_in[i] = acc_ff[i+1];
               end
               acc_in[LIMBS-1] = acc_ff[0];
               cnt_in          = cnt_ff + 1'b1;
               if (cnt_ff == CNT_LAST) begin
                  cnt_in   = '0;
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         for (int i = 0; i < LIMBS; i++) begin
            acc_ff[i] <= '0;
         end
         status_ff    <= STATUS_OK;
         pos_ff       <= 2'd0;
         fwz_ff       <= 1'b0;
         mode_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         acc_ff       <= acc_in;
         status_ff    <= status_in;
         pos_ff       <= pos_in;
         fwz_ff       <= fwz_in;
         mode_ff      <= mode_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      carry_ff <= carry_in;
      hex_ff   <= hex_in;
      final_ff <= final_in;
      rsp_ff   <= rsp_in;
   end

   assign req_stall   = (state_ff != ST_IDLE);
   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_ff;

endmodule

>>> hw/rtl/anl_checker.sv
// Port-level checker for ascii_number_to_limbs_core, with its bind.
// Uses anl_pkg for payload types and status codes.

module anl_checker
   import anl_pkg::*;
#(
   parameter int LIMBS = 4
) (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input anl_rsp_type rsp_payload
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_payload))
      else $error("rsp item changed while stalled");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.status == STATUS_OK)
                    || (rsp_payload.status == STATUS_INVALID)
                    || (rsp_payload.status == STATUS_OVERFLOW))
      else $error("rsp status code out of range");

   a_last_index: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_payload.last_limb == (rsp_payload.limb_index == 4'(LIMBS - 1))))
      else $error("last_limb does not match limb_index");

   // mid-run limbs pending means the sequencer is still emitting
   a_busy_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_payload.last_limb |-> req_stall)
      else $error("req accepted during limb emission");

   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("rsp valid right after reset");

endmodule

bind ascii_number_to_limbs_core anl_checker #(.LIMBS(LIMBS)) u_anl_checker (
   .clock       (clock),
   .reset       (reset),
   .req_stall   (req_stall),
   .rsp_valid   (rsp_valid),
   .rsp_stall   (rsp_stall),
   .rsp_payload (rsp_payload)
);

>>> tb/ascii_number_to_limbs_core_tb.sv
// Self-checking testbench for ascii_number_to_limbs_core: decimal and hex parsing,
// prefix handling, invalid characters and overflow, with random pacing on both sides.
// Depends on anl_pkg and the core RTL only.

module ascii_number_to_limbs_core_tb;
   import anl_pkg::*;

   localparam int LIMBS = 4;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   anl_req_type req_payload = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   anl_rsp_type rsp_payload;
   logic        csr_wr_en = 1'b0;
   logic        csr_wr_data = 1'b0;

   // local copy of the parser state
   logic [63:0] num_acc [LIMBS];
   logic [1:0]  num_status;
   logic [1:0]  num_pos;
   logic        num_first_zero;
   logic        base_hex;

   anl_rsp_type expected_limbs [$];
   int          mismatches = 0;
   int          chars_accepted = 0;
   bit          pace_on = 1'b1;

   ascii_number_to_limbs_core #(.LIMBS(LIMBS)) uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #10 clock = ~clock;
   end

   initial begin
      #6000000;
      $display("ascii_number_to_limbs_core_tb: FAIL");
      $finish;
   end

   function automatic void clear_number();
      for (int i = 0; i < LIMBS; i++)
         num_acc[i] = '0;
      num_status = STATUS_OK;
      num_pos = 2'd0;
      num_first_zero = 1'b0;
   endfunction

   // bit 4 set when the character is a digit of the current base
   function automatic logic [4:0] digit_of(input logic [7:0] c);
      if (c >= CH_0 && c <= CH_9)
         return {1'b1, 4'(c - CH_0)};
      if (base_hex && c >= CH_LO_A && c <= CH_LO_F)
         return {1'b1, 4'(c - CH_LO_A + 8'd10)};
      if (base_hex && c >= CH_UP_A && c <= CH_UP_F)
         return {1'b1, 4'(c - CH_UP_A + 8'd10)};
      return 5'd0;
   endfunction

   function automatic void parse_char(input anl_req_type it);
      logic [4:0]  dig;
      logic [3:0]  carry;
      logic [67:0] wide;
      logic        skip;
      anl_rsp_type limb;
      if (it.start_new)
         clear_number();
      if (num_status == STATUS_OK) begin
         skip = base_hex && num_pos == 2'd1 && num_first_zero &&
                (it.char_code == CH_LO_X || it.char_code == CH_UP_X);
         if (!skip) begin
            dig = digit_of(it.char_code);
            if (!dig[4]) begin
               num_status = STATUS_INVALID;
            end else begin
               carry = dig[3:0];
               for (int i = 0; i < LIMBS; i++) begin
                  wide = {4'd0, num_acc[i]} * (base_hex ? 68'd16 : 68'd10) + {64'd0, carry};
                  num_acc[i] = wide[63:0];
                  carry = wide[67:64];
               end
               if (carry != 4'd0)
                  num_status = STATUS_OVERFLOW;
            end
         end
         if (num_pos == 2'd0)
            num_first_zero = (it.char_code == CH_0);
         if (num_pos < 2'd2)
            num_pos = num_pos + 2'd1;
      end
      if (it.final_char) begin
         for (int i = 0; i < LIMBS; i++) begin
            limb.limb_value = num_acc[i];
            limb.limb_index = 4'(i);
            limb.status = num_status;
            limb.last_limb = (i == LIMBS - 1);
            expected_limbs.insert(expected_limbs.size(), limb);
         end
      end
   endfunction

   function automatic logic [7:0] random_digit();
      int n;
      n = $urandom_range(0, base_hex ? 21 : 9);
      if (n < 10)
         return CH_0 + 8'(n);
      if (n < 16)
         return CH_LO_A + 8'(n - 10);
      return CH_UP_A + 8'(n - 16);
   endfunction

   function automatic void report_field(input string field, input logic [63:0] want,
                                        input logic [63:0] got);
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
      mismatches++;
   endfunction

   // result side: random stall before each limb
   initial begin : limb_pacing
      int hold;
      forever begin
         hold = pace_on ? $urandom_range(0, 16) : 0;
         if (hold > 0) begin
            rsp_stall <= 1'b1;
            repeat (hold) @(posedge clock);
         end
         rsp_stall <= 1'b0;
         do @(posedge clock); while (reset || !(rsp_valid && !rsp_stall));
      end
   end

   always @(posedge clock) begin : limb_check
      anl_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_limbs.size() == 0) begin
            $display("%0t: unexpected limb, expected none, got %h", $time, rsp_payload);
            mismatches++;
         end else begin
            want = expected_limbs.pop_front();
            if (rsp_payload.limb_value !== want.limb_value)
               report_field("limb_value", want.limb_value, rsp_payload.limb_value);
            if (rsp_payload.limb_index !== want.limb_index)
               report_field("limb_index", want.limb_index, rsp_payload.limb_index);
            if (rsp_payload.status !== want.status)
               report_field("status", want.status, rsp_payload.status);
            if (rsp_payload.last_limb !== want.last_limb)
               report_field("last_limb", want.last_limb, rsp_payload.last_limb);
         end
      end
   end

   task automatic send_char(input bit is_first, input logic [7:0] code, input bit is_last);
      int gap;
      anl_req_type it;
      it.start_new = is_first;
      it.char_code = code;
      it.final_char = is_last;
      gap = pace_on ? $urandom_range(0, 16) : 0;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= it;
      do @(posedge clock); while (req_stall);
      parse_char(it);
      chars_accepted++;
   endtask

   task automatic send_text(input string s, input bit is_first, input bit is_last);
      for (int i = 0; i < s.len(); i++)
         send_char(is_first && i == 0, s[i], is_last && i == s.len() - 1);
   endtask

   // wait for all limbs, then let a trailing non-final character finish
   task automatic drain();
      int guard;
      req_valid <= 1'b0;
      guard = 0;
      while (expected_limbs.size() != 0 && guard < 4000) begin
         @(posedge clock);
         guard++;
      end
      repeat (2 * LIMBS + 4) @(posedge clock);
   endtask

   task automatic write_base(input bit hex);
      drain();
      csr_wr_en <= 1'b1;
      csr_wr_data <= hex;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      base_hex = hex;
   endtask

   // dense: leading digit and most others are the largest digit, for overflow runs
   task automatic send_random_number(input int len, input bit dense);
      bit         is_first;
      bit         is_last;
      logic [7:0] code;
      is_first = dense || $urandom_range(0, 9) != 0;
      if (base_hex && $urandom_range(0, 2) == 0) begin
         send_char(is_first, CH_0, 1'b0);
         send_char(1'b0, $urandom_range(0, 1) ? CH_LO_X : CH_UP_X, 1'b0);
         is_first = 1'b0;
      end
      for (int i = 0; i < len; i++) begin
         if (!dense && $urandom_range(0, 15) == 0)
            code = 8'($urandom_range(0, 255));
         else if (dense && (i == 0 || $urandom_range(0, 3) != 0))
            code = base_hex ? CH_LO_F : CH_9;
         else
            code = random_digit();
         if (i == len - 1)
            is_last = dense || $urandom_range(0, 9) != 0;
         else
            is_last = $urandom_range(0, 19) == 0;
         send_char(is_first && i == 0, code, is_last);
      end
   endtask

   task automatic test_decimal_directed();
      pace_on = 1'b1;
      write_base(1'b0);
      send_text("0", 1'b1, 1'b1);
      send_text("9", 1'b1, 1'b1);
      send_char(1'b1, 8'h2F, 1'b1);
      send_char(1'b1, 8'h3A, 1'b0);
      send_char(1'b0, CH_0, 1'b1);          // error holds across characters
      send_text("12", 1'b1, 1'b1);
      send_text("3", 1'b0, 1'b1);           // continues after final
      send_char(1'b1, 8'h00, 1'b1);
      send_char(1'b1, 8'hFF, 1'b1);
      send_text("5a7", 1'b1, 1'b1);         // hex letter invalid in decimal
   endtask

   task automatic test_hex_directed();
      pace_on = 1'b0;
      write_base(1'b1);
      send_text("0x", 1'b1, 1'b1);
      send_text("0XaF", 1'b1, 1'b1);
      send_text("Af", 1'b1, 1'b1);
      send_text("x", 1'b1, 1'b1);
      send_text("1x", 1'b1, 1'b1);
      send_text("00x", 1'b1, 1'b1);
      send_text("0", 1'b1, 1'b1);
      send_text("X", 1'b0, 1'b1);           // prefix split across a final
      send_text("@G`g", 1'b1, 1'b1);
      send_char(1'b1, 8'h80, 1'b1);
   endtask

   task automatic test_overflow_runs();
      pace_on = 1'b1;
      send_random_number($urandom_range(64, 66), 1'b1);
      write_base(1'b0);
      pace_on = 1'b0;
      send_random_number($urandom_range(79, 80), 1'b1);
   endtask

   task automatic test_random_numbers();
      int target;
      for (int phase = 0; phase < 4; phase++) begin
         write_base(phase == 1 || phase == 2);
         pace_on = (phase != 2);
         target = chars_accepted + 6;
         while (chars_accepted < target)
            send_random_number($urandom_range(1, 12), 1'b0);
      end
   endtask

   initial begin
      base_hex = 1'b0;
      clear_number();
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_decimal_directed();
      test_hex_directed();
      test_overflow_runs();
      test_random_numbers();
      drain();
      if (expected_limbs.size() != 0) begin
         $display("%0t: limbs missing, expected %0d more, got 0", $time, expected_limbs.size());
         mismatches++;
      end
      if (mismatches == 0)
         $display("ascii_number_to_limbs_core_tb: PASS");
      else
         $display("ascii_number_to_limbs_core_tb: FAIL");
      $finish;
   end

endmodule
